>>> hdl/tlrq_pkg.sv
// Shared types and codes for the tree lca range query unit.
`timescale 1ns / 1ps
`default_nettype none

package tlrq_pkg;

  typedef enum logic [2:0] {
    KIND_WRITE     = 3'd0,
    KIND_LCA       = 3'd1,
    KIND_GCD       = 3'd2,
    KIND_IN_RANGE  = 3'd3,
    KIND_INTERSECT = 3'd4,
    KIND_CONTAINED = 3'd5,
    KIND_LUB       = 3'd6,
    KIND_GLB       = 3'd7
  } kind_t;

  // Request from the sequencer to the walk unit.
  typedef struct packed {
    logic start;
    logic is_gcd;
    logic walk_mode;
  } walk_ctl_t;

  // Status from the walk unit back to the sequencer.
  typedef struct packed {
    logic done;
    logic err;
  } walk_sts_t;

endpackage

`default_nettype wire

>>> hdl/tree_lca_range_query_unit.sv
// Top level of the tree lca range query unit: item sequencer and output register.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one item per transfer: kind and four
//   node fields. Kind 0 writes a parent entry; kinds 1..7 are queries. The output
//   channel (out_valid / out_stall) returns exactly one result per item.
//   cfg_we / cfg_wdata write walk_mode; write it only while the unit is idle.
// Sequencing:
//   One item is in work at a time. A write runs no walk, kinds 1 and 2 run one
//   walk, kinds 3..7 run two. A walk climbs one parent step per parent memory
//   read, at most NODES steps; it goes straight to its result when an operand
//   is bottom or top, and in plain ordering (walk_mode 0). The next item is
//   accepted from the cycle after its predecessor's result is loaded.
// Reset:
//   rst is synchronous: empty the output register, return to idle, set walk_mode
//   to 1. The parent memory is not cleared and holds nothing usable until written.
// Stall:
//   A finished result holds in the output register while out_stall is high; the
//   next item is accepted meanwhile and holds in its final stage until then.
`timescale 1ns / 1ps
`default_nettype none

module tree_lca_range_query_unit #(
  parameter int NODES = 1024,
  localparam int NODE_W = $clog2(NODES + 2),
  localparam int ADDR_W = $clog2(NODES)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [2:0]        kind,
  input  wire logic [NODE_W-1:0] first_node,
  input  wire logic [NODE_W-1:0] second_node,
  input  wire logic [NODE_W-1:0] third_node,
  input  wire logic [NODE_W-1:0] fourth_node,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [NODE_W-1:0]      node_out,
  output logic [NODE_W-1:0]      range_lo_out,
  output logic [NODE_W-1:0]      range_hi_out,
  output logic                   truth,
  output logic                   walk_error
);

  localparam logic [NODE_W-1:0] BOT = NODE_W'(NODES);
  localparam logic [NODE_W-1:0] TOP = NODE_W'(NODES + 1);

  typedef enum logic [2:0] {S_IDLE, S_W1_GO, S_W1, S_W2_GO, S_W2, S_FIN} state_t;

  state_t              state;
  tlrq_pkg::kind_t     kind_r;
  logic [NODE_W-1:0]   n1, n2, n3, n4, r1, r2;
  logic                err_acc, walk_mode;

  tlrq_pkg::walk_ctl_t ctl;
  tlrq_pkg::walk_sts_t sts;
  logic [NODE_W-1:0]   wx, wy, wres, wr_data;
  logic                second, two_walks, wr_en, out_free, fin_load;
  logic [NODE_W-1:0]   node_c, rlo_c, rhi_c;
  logic                truth_c;

  // Clamp codes above top to top.
  function automatic logic [NODE_W-1:0] norm(input logic [NODE_W-1:0] v);
    return (v > TOP) ? TOP : v;
  endfunction

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign fin_load = (state == S_FIN) && out_free;
  assign second   = (state == S_W2_GO);
  assign two_walks = kind_r inside {tlrq_pkg::KIND_IN_RANGE, tlrq_pkg::KIND_INTERSECT,
                                    tlrq_pkg::KIND_CONTAINED, tlrq_pkg::KIND_LUB,
                                    tlrq_pkg::KIND_GLB};

  // Parent write goes straight to the memory on the input transfer.
  assign wr_en   = (state == S_IDLE) && in_valid && (kind == tlrq_pkg::KIND_WRITE) &&
                   (first_node < BOT);
  assign wr_data = (norm(second_node) >= BOT) ? TOP : second_node;

  // Operands of the first and second walk for each query kind.
  always_comb begin
    wx = n1;
    wy = n2;
    ctl.is_gcd = 1'b0;
    case (kind_r)
      tlrq_pkg::KIND_GCD: begin
        ctl.is_gcd = 1'b1;
      end
      tlrq_pkg::KIND_IN_RANGE: begin
        wx = second ? n4 : n3;
        wy = n1;
        ctl.is_gcd = second;
      end
      tlrq_pkg::KIND_INTERSECT: begin
        wx = second ? n2 : n1;
        wy = second ? n3 : n4;
      end
      tlrq_pkg::KIND_CONTAINED: begin
        wx = second ? n2 : n3;
        wy = second ? n4 : n1;
      end
      tlrq_pkg::KIND_LUB: begin
        wx = second ? n2 : n1;
        wy = second ? n4 : n3;
        ctl.is_gcd = !second;
      end
      tlrq_pkg::KIND_GLB: begin
        wx = second ? n2 : n1;
        wy = second ? n4 : n3;
        ctl.is_gcd = second;
      end
      default: begin
        wx = n1;
        wy = n2;
      end
    endcase
    ctl.start     = (state == S_W1_GO) || (state == S_W2_GO);
    ctl.walk_mode = walk_mode;
  end

  // Result fields from the walk results.
  always_comb begin
    node_c  = '0;
    rlo_c   = '0;
    rhi_c   = '0;
    truth_c = 1'b0;
    case (kind_r)
      tlrq_pkg::KIND_LCA,
      tlrq_pkg::KIND_GCD:       node_c = r1;
      tlrq_pkg::KIND_IN_RANGE:  truth_c = (r1 == n1) && (r2 == n1);
      tlrq_pkg::KIND_INTERSECT: truth_c = (r1 == n4) && (r2 == n2);
      tlrq_pkg::KIND_CONTAINED: truth_c = (r1 == n1) && (r2 == n4);
      tlrq_pkg::KIND_LUB,
      tlrq_pkg::KIND_GLB: begin
        rlo_c = r1;
        rhi_c = r2;
      end
      default: node_c = '0;
    endcase
  end

  tlrq_walker #(.NODES(NODES)) u_walker (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .x       (wx),
    .y       (wy),
    .wr_en   (wr_en),
    .wr_addr (first_node[ADDR_W-1:0]),
    .wr_data (wr_data),
    .sts     (sts),
    .res     (wres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      walk_mode <= 1'b1;
    end else begin
      if (cfg_we) begin
        walk_mode <= cfg_wdata;
      end
      // Drop the result once the receiver takes it, unless the next one loads now.
      if (out_valid && !out_stall && !fin_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind_r  <= tlrq_pkg::kind_t'(kind);
            n1      <= norm(first_node);
            n2      <= norm(second_node);
            n3      <= norm(third_node);
            n4      <= norm(fourth_node);
            r1      <= '0;
            r2      <= '0;
            err_acc <= 1'b0;
            state   <= (kind == tlrq_pkg::KIND_WRITE) ? S_FIN : S_W1_GO;
          end
        end
        S_W1_GO: state <= S_W1;
        S_W1: begin
          if (sts.done) begin
            r1      <= wres;
            err_acc <= err_acc | sts.err;
            state   <= two_walks ? S_W2_GO : S_FIN;
          end
        end
        S_W2_GO: state <= S_W2;
        S_W2: begin
          if (sts.done) begin
            r2      <= wres;
            err_acc <= err_acc | sts.err;
            state   <= S_FIN;
          end
        end
        S_FIN: begin
          // Hold here until the output register is free.
          if (fin_load) begin
            out_valid    <= 1'b1;
            node_out     <= node_c;
            range_lo_out <= rlo_c;
            range_hi_out <= rhi_c;
            truth        <= truth_c;
            walk_error   <= err_acc;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/tlrq_walker.sv
// Parent table memory and the lca/gcd parent walk engine.
`timescale 1ns / 1ps
`default_nettype none

module tlrq_walker #(
  parameter int NODES = 1024,
  localparam int NODE_W = $clog2(NODES + 2),
  localparam int ADDR_W = $clog2(NODES)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tlrq_pkg::walk_ctl_t ctl,
  input  wire logic [NODE_W-1:0]   x,
  input  wire logic [NODE_W-1:0]   y,
  input  wire logic                wr_en,
  input  wire logic [ADDR_W-1:0]   wr_addr,
  input  wire logic [NODE_W-1:0]   wr_data,
  output tlrq_pkg::walk_sts_t      sts,
  output logic [NODE_W-1:0]        res
);

  localparam int STEP_W = $clog2(NODES + 1);
  localparam logic [NODE_W-1:0] BOT = NODE_W'(NODES);
  localparam logic [NODE_W-1:0] TOP = NODE_W'(NODES + 1);

  typedef enum logic [1:0] {W_IDLE, W_RUN, W_POST} wstate_t;

  logic [NODE_W-1:0] mem [NODES];
  logic [NODE_W-1:0] rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_en;

  wstate_t           state;
  logic [NODE_W-1:0] a, b, x0, y0, m;
  logic              pend_a, pend_b, gcd_r, done, walk_err;
  logic [STEP_W-1:0] steps;

  logic [NODE_W-1:0] cur_a, cur_b, lca_nt, gcd_nt;
  logic              a_lt, eq, big, over;

  // Current pair: take the parent just read in place of the side that climbed.
  always_comb begin
    cur_a   = pend_a ? rd_data : a;
    cur_b   = pend_b ? rd_data : b;
    a_lt    = cur_a < cur_b;
    eq      = cur_a == cur_b;
    big     = (cur_a >= BOT) || (cur_b >= BOT);
    over    = steps == STEP_W'(NODES);
    rd_addr = a_lt ? cur_a[ADDR_W-1:0] : cur_b[ADDR_W-1:0];
    rd_en   = (state == W_RUN) && !eq && !big && !over;
  end

  // Plain ordering: bottom lowest, then real nodes, then top.
  always_comb begin
    if (x == BOT) begin
      lca_nt = y;
      gcd_nt = x;
    end else if (y == BOT) begin
      lca_nt = x;
      gcd_nt = y;
    end else begin
      lca_nt = (x >= y) ? x : y;
      gcd_nt = (x <= y) ? x : y;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= W_IDLE;
      done     <= 1'b0;
      walk_err <= 1'b0;
      pend_a   <= 1'b0;
      pend_b   <= 1'b0;
    end else begin
      case (state)
        W_IDLE: begin
          done <= ctl.start && !ctl.walk_mode;
          if (ctl.start) begin
            x0       <= x;
            y0       <= y;
            a        <= x;
            b        <= y;
            gcd_r    <= ctl.is_gcd;
            pend_a   <= 1'b0;
            pend_b   <= 1'b0;
            steps    <= '0;
            walk_err <= 1'b0;
            if (!ctl.walk_mode) begin
              res <= ctl.is_gcd ? gcd_nt : lca_nt;
            end else if (x == BOT) begin
              m     <= y;
              state <= W_POST;
            end else if (y == BOT) begin
              m     <= x;
              state <= W_POST;
            end else if ((x == TOP) || (y == TOP)) begin
              m     <= TOP;
              state <= W_POST;
            end else begin
              state <= W_RUN;
            end
          end
        end
        W_RUN: begin
          if (eq) begin
            m     <= cur_a;
            state <= W_POST;
          end else if (big) begin
            m     <= TOP;
            state <= W_POST;
          end else if (over) begin
            // Runaway walk: give top and flag it.
            m        <= TOP;
            walk_err <= 1'b1;
            state    <= W_POST;
          end else begin
            a      <= cur_a;
            b      <= cur_b;
            pend_a <= a_lt;
            pend_b <= !a_lt;
            steps  <= steps + STEP_W'(1);
          end
        end
        W_POST: begin
          pend_a <= 1'b0;
          pend_b <= 1'b0;
          if (!gcd_r) begin
            res <= m;
          end else if (m == x0) begin
            res <= y0;
          end else if (m == y0) begin
            res <= x0;
          end else begin
            res <= BOT;
          end
          done  <= 1'b1;
          state <= W_IDLE;
        end
        default: state <= W_IDLE;
      endcase
    end
  end

  assign sts = '{done: done, err: walk_err};

endmodule

`default_nettype wire

>>> hdl/tlrq_checker.sv
// Port-level checker for the tree lca range query unit, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module tlrq_checker #(
  parameter int NODES = 1024,
  localparam int NODE_W = $clog2(NODES + 2)
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [NODE_W-1:0] node_out,
  input wire logic [NODE_W-1:0] range_lo_out,
  input wire logic [NODE_W-1:0] range_hi_out,
  input wire logic              truth
);

  localparam logic [NODE_W-1:0] TOP = NODE_W'(NODES + 1);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(node_out) &&
      $stable(range_lo_out) && $stable(range_hi_out) && $stable(truth))
    else $error("stalled result changed");

  // One item in work at a time: a transfer closes the input side.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after a transfer");

  // Result nodes stay within the node codes.
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (node_out <= TOP) && (range_lo_out <= TOP) && (range_hi_out <= TOP))
    else $error("result node code above top");

  // A node result carries no range or truth answer.
  a_node_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && (node_out != '0) |->
      (range_lo_out == '0) && (range_hi_out == '0) && !truth)
    else $error("node result mixed with other fields");

endmodule

bind tree_lca_range_query_unit tlrq_checker #(.NODES(NODES)) u_tlrq_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .node_out     (node_out),
  .range_lo_out (range_lo_out),
  .range_hi_out (range_hi_out),
  .truth        (truth)
);

`default_nettype wire
